// ===== rtl/core/sliding_window_min_max_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sliding window min/max assertion macros
// shared concurrent check helpers, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SWMM_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWMM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// shared types and constants of the sliding window min/max unit
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int CFG_WIDTH = 7;

    // per-item control broadcast to every cell of the chain
    typedef struct packed {
        logic fire;
        logic restart;
        logic shift_min;
        logic shift_max;
    } t_cell_ctrl;

    // survivor flags handed from a cell to its right neighbor
    typedef struct packed {
        logic min_keep;
        logic max_keep;
    } t_keep;

endpackage

// ===== rtl/core/sliding_window_min_max_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max_unit
// running minimum and maximum over the last window_size signed samples
// ----------------------------------------------------------------------------
// The unit takes one sample item per clock while o_s_tready is high and, once
// window_size samples of the current stream are in, returns the window
// minimum and maximum for every item. Both monotonic queues live in a chain
// of WINDOW_MAX cells whose head is cell 0; the result is read straight from
// the head cell, so it is held there until taken and the next item is
// accepted in the same cycle as the result leaves. After a write that shrinks
// the window, the chain drops expired head entries one per cycle once the
// next item is offered and no result waits, and input ready stays low while
// they drain. A sample with tuser set starts a new stream and empties both
// queues.
`include "sliding_window_min_max_unit_macros.svh"

module sliding_window_min_max_unit #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wen,
    input  logic [swmm_pkg::CFG_WIDTH-1:0]          i_cfg_wdata,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // restart
    input  logic                                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // window_min, window_max
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     o_m_tdata
);
    import swmm_pkg::*;

    localparam int AW  = $clog2(WINDOW_MAX);
    localparam int FW  = $clog2(WINDOW_MAX + 1);
    localparam int TDO = ((2*SAMPLE_WIDTH+7)/8)*8;

    logic [CFG_WIDTH-1:0]           r_window_size;
    logic [FW-1:0]                  r_fill, n_fill;
    logic                           r_out_valid, n_out_valid;
    logic [FW-1:0]                  w_eff;
    logic [AW-1:0]                  w_m1;
    logic [FW-1:0]                  fill_base;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           exp0_min, exp0_max, exp1_min, exp1_max;
    logic                           clean_ok;
    logic                           s_ready;
    logic                           fire;
    t_cell_ctrl                     ctrl;

    logic                           min_valid [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] min_value [WINDOW_MAX];
    logic        [AW-1:0]           min_age   [WINDOW_MAX];
    logic                           max_valid [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] max_value [WINDOW_MAX];
    logic        [AW-1:0]           max_age   [WINDOW_MAX];
    t_keep                          keep      [WINDOW_MAX];

    assign sample = i_s_tdata[SAMPLE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_WIDTH'(1);
        end else if (i_cfg_wen) begin
            r_window_size <= i_cfg_wdata;
        end
    end

    // zero means one, anything above the chain length saturates
    always_comb begin
        if (r_window_size == '0) begin
            w_eff = FW'(1);
        end else if (32'(r_window_size) > 32'(WINDOW_MAX)) begin
            w_eff = FW'(WINDOW_MAX);
        end else begin
            w_eff = FW'(r_window_size);
        end
        w_m1 = AW'(w_eff - FW'(1));
    end

    // head entry expires when its age after this item reaches the window
    always_comb begin
        exp0_min = min_valid[0] && (min_age[0] >= w_m1);
        exp0_max = max_valid[0] && (max_age[0] >= w_m1);
        exp1_min = min_valid[1] && (min_age[1] >= w_m1);
        exp1_max = max_valid[1] && (max_age[1] >= w_m1);
    end

    assign clean_ok = !(exp1_min || exp1_max);
    assign s_ready  = clean_ok && (!r_out_valid || i_m_tready);
    assign fire     = i_s_tvalid && s_ready;

    // while a result waits in the head cell the chain holds still
    always_comb begin
        ctrl.fire    = fire;
        ctrl.restart = i_s_tuser;
        if (fire) begin
            ctrl.shift_min = !i_s_tuser && exp0_min;
            ctrl.shift_max = !i_s_tuser && exp0_max;
        end else begin
            // stale heads go only while an item is offered, so a later
            // window write still sees every entry the last item kept
            ctrl.shift_min = i_s_tvalid && !r_out_valid && exp0_min;
            ctrl.shift_max = i_s_tvalid && !r_out_valid && exp0_max;
        end
    end

    always_comb begin
        fill_base   = i_s_tuser ? '0 : r_fill;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        if (fire) begin
            if (fill_base == FW'(WINDOW_MAX)) begin
                n_fill = fill_base;
            end else begin
                n_fill = fill_base + FW'(1);
            end
            n_out_valid = (n_fill >= w_eff);
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        t_keep                          left_keep;
        logic                           nxt_min_valid;
        logic signed [SAMPLE_WIDTH-1:0] nxt_min_value;
        logic        [AW-1:0]           nxt_min_age;
        logic                           nxt_max_valid;
        logic signed [SAMPLE_WIDTH-1:0] nxt_max_value;
        logic        [AW-1:0]           nxt_max_age;

        if (gi == 0) begin : g_head
            assign left_keep = '{min_keep: 1'b1, max_keep: 1'b1};
        end else begin : g_body
            assign left_keep = keep[gi-1];
        end

        if (gi == WINDOW_MAX - 1) begin : g_tail
            assign nxt_min_valid = 1'b0;
            assign nxt_min_value = '0;
            assign nxt_min_age   = '0;
            assign nxt_max_valid = 1'b0;
            assign nxt_max_value = '0;
            assign nxt_max_age   = '0;
        end else begin : g_link
            assign nxt_min_valid = min_valid[gi+1];
            assign nxt_min_value = min_value[gi+1];
            assign nxt_min_age   = min_age[gi+1];
            assign nxt_max_valid = max_valid[gi+1];
            assign nxt_max_value = max_value[gi+1];
            assign nxt_max_age   = max_age[gi+1];
        end

        swmm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AW)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (ctrl),
            .i_sample        (sample),
            .i_left_keep     (left_keep),
            .i_nxt_min_valid (nxt_min_valid),
            .i_nxt_min_value (nxt_min_value),
            .i_nxt_min_age   (nxt_min_age),
            .i_nxt_max_valid (nxt_max_valid),
            .i_nxt_max_value (nxt_max_value),
            .i_nxt_max_age   (nxt_max_age),
            .o_keep          (keep[gi]),
            .o_min_valid     (min_valid[gi]),
            .o_min_value     (min_value[gi]),
            .o_min_age       (min_age[gi]),
            .o_max_valid     (max_valid[gi]),
            .o_max_value     (max_value[gi]),
            .o_max_age       (max_age[gi])
        );
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDO'({max_value[0], min_value[0]});

    `SWMM_CHECK_NEXT(a_head_filled, fire, min_valid[0] && max_valid[0], "queue head empty after item")
    `SWMM_CHECK_NOW(a_min_le_max, r_out_valid, min_value[0] <= max_value[0], "window min above max")
    `SWMM_CHECK_NEXT(a_restart_fill, fire && i_s_tuser, r_fill == FW'(1), "fill count wrong after restart")

endmodule

// ===== rtl/core/swmm_cell.sv =====
// ----------------------------------------------------------------------------
// swmm_cell
// one slot of the min queue and one slot of the max queue, shifting toward
// the head and taking the new item where the surviving run ends
// ----------------------------------------------------------------------------
module swmm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_WIDTH    = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swmm_pkg::t_cell_ctrl           i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  swmm_pkg::t_keep                i_left_keep,
    input  logic                           i_nxt_min_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_nxt_min_value,
    input  logic        [AGE_WIDTH-1:0]    i_nxt_min_age,
    input  logic                           i_nxt_max_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_nxt_max_value,
    input  logic        [AGE_WIDTH-1:0]    i_nxt_max_age,
    output swmm_pkg::t_keep                o_keep,
    output logic                           o_min_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_min_value,
    output logic        [AGE_WIDTH-1:0]    o_min_age,
    output logic                           o_max_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_max_value,
    output logic        [AGE_WIDTH-1:0]    o_max_age
);
    import swmm_pkg::*;

    logic                           r_min_valid, n_min_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_min_value, n_min_value;
    logic        [AGE_WIDTH-1:0]    r_min_age,   n_min_age;
    logic                           r_max_valid, n_max_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_max_value, n_max_value;
    logic        [AGE_WIDTH-1:0]    r_max_age,   n_max_age;

    logic                           src_min_valid;
    logic signed [SAMPLE_WIDTH-1:0] src_min_value;
    logic        [AGE_WIDTH-1:0]    src_min_age;
    logic                           src_max_valid;
    logic signed [SAMPLE_WIDTH-1:0] src_max_value;
    logic        [AGE_WIDTH-1:0]    src_max_age;
    t_keep                          keep;

    // source slot: own contents, or the right neighbor when the head expires
    always_comb begin
        if (i_ctrl.shift_min) begin
            src_min_valid = i_nxt_min_valid;
            src_min_value = i_nxt_min_value;
            src_min_age   = i_nxt_min_age;
        end else begin
            src_min_valid = r_min_valid;
            src_min_value = r_min_value;
            src_min_age   = r_min_age;
        end
        if (i_ctrl.shift_max) begin
            src_max_valid = i_nxt_max_valid;
            src_max_value = i_nxt_max_value;
            src_max_age   = i_nxt_max_age;
        end else begin
            src_max_valid = r_max_valid;
            src_max_value = r_max_value;
            src_max_age   = r_max_age;
        end
    end

    // an entry survives the item only if it beats the new sample strictly
    always_comb begin
        keep.min_keep = i_ctrl.fire && !i_ctrl.restart && src_min_valid &&
                        (src_min_value < i_sample);
        keep.max_keep = i_ctrl.fire && !i_ctrl.restart && src_max_valid &&
                        (src_max_value > i_sample);
    end

    always_comb begin
        n_min_valid = src_min_valid;
        n_min_value = src_min_value;
        n_min_age   = src_min_age;
        n_max_valid = src_max_valid;
        n_max_value = src_max_value;
        n_max_age   = src_max_age;
        if (i_ctrl.fire) begin
            // first slot past the survivors takes the new sample
            if (keep.min_keep) begin
                n_min_valid = 1'b1;
                n_min_age   = src_min_age + AGE_WIDTH'(1);
            end else if (i_left_keep.min_keep) begin
                n_min_valid = 1'b1;
                n_min_value = i_sample;
                n_min_age   = '0;
            end else begin
                n_min_valid = 1'b0;
            end
            if (keep.max_keep) begin
                n_max_valid = 1'b1;
                n_max_age   = src_max_age + AGE_WIDTH'(1);
            end else if (i_left_keep.max_keep) begin
                n_max_valid = 1'b1;
                n_max_value = i_sample;
                n_max_age   = '0;
            end else begin
                n_max_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_valid <= 1'b0;
            r_max_valid <= 1'b0;
        end else begin
            r_min_valid <= n_min_valid;
            r_max_valid <= n_max_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_value <= n_min_value;
        r_min_age   <= n_min_age;
        r_max_value <= n_max_value;
        r_max_age   <= n_max_age;
    end

    assign o_keep      = keep;
    assign o_min_valid = r_min_valid;
    assign o_min_value = r_min_value;
    assign o_min_age   = r_min_age;
    assign o_max_valid = r_max_valid;
    assign o_max_value = r_max_value;
    assign o_max_age   = r_max_age;

endmodule

// ===== tb/tb_sliding_window_min_max_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max_unit
// self-checking bench for the sliding window min/max unit
// ----------------------------------------------------------------------------
// A queue-based predictor tracks the running minimum and maximum of every
// accepted sample item and queues the window result that each one should
// produce. Each returned result is checked against the oldest queued one.
// Directed items cover sample extremes, restarts, equal samples, the fill
// phase, odd window sizes, and shrinking and widening mid-stream. A long
// output stall and a random part over many window sizes follow, with random
// idling on both stream sides.
module tb_sliding_window_min_max_unit;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 400;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] val;
        logic [6:0]                     pos;
    } t_held;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
    } t_window;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_wen   = 1'b0;
    logic [swmm_pkg::CFG_WIDTH-1:0] i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [31:0]                    i_s_tdata   = '0;
    logic                           i_s_tuser   = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [63:0]                    o_m_tdata;

    // predictor state
    t_held      min_held[$];
    t_held      max_held[$];
    t_window    expected_windows[$];
    logic [6:0] next_pos     = '0;
    int         stream_fill  = 0;
    logic [6:0] window_reg   = 7'd1;

    bit         no_gaps      = 1'b0;
    int         hold_cycles  = 0;
    int         mismatches   = 0;
    int         samples_sent = 0;
    int         random_sent  = 0;
    int         results_seen = 0;
    int         sizes_used   = 0;

    sliding_window_min_max_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic int active_window();
        if (window_reg == 0) return 1;
        if (window_reg > WINDOW_MAX) return WINDOW_MAX;
        return int'(window_reg);
    endfunction

    // drop entries that left the window, then keep the chain monotonic
    function automatic void refresh_held(ref t_held q[$], input logic signed [31:0] x,
                                         input logic [6:0] now, input int w,
                                         input bit keep_min);
        t_held e;
        while (q.size() > 0 && int'(7'(now - q[0].pos)) >= w) q.delete(0);
        while (q.size() > 0 && (keep_min ? (q[$].val >= x) : (q[$].val <= x)))
            q.delete(q.size() - 1);
        if (q.size() < WINDOW_MAX) begin
            e.val = x;
            e.pos = now;
            q.insert(q.size(), e);
        end
    endfunction

    function automatic void track_sample(input logic [31:0] sample_in, input logic restart);
        logic [6:0] now;
        int         w;
        t_window    r;
        w = active_window();
        if (restart) begin
            min_held.delete();
            max_held.delete();
            stream_fill = 0;
            next_pos = '0;
        end
        now = next_pos;
        next_pos = next_pos + 7'd1;
        refresh_held(min_held, sample_in, now, w, 1'b1);
        refresh_held(max_held, sample_in, now, w, 1'b0);
        if (stream_fill < WINDOW_MAX) stream_fill++;
        if (stream_fill >= w) begin
            r.lo = min_held[0].val;
            r.hi = max_held[0].val;
            expected_windows.insert(expected_windows.size(), r);
        end
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 8) - 4;
            4, 5, 6: return $urandom();
            7: return 32'h8000_0000 + $urandom_range(0, 3);
            8: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic [31:0] sample_in, input logic restart);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sample_in;
        i_s_tuser  <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        track_sample(sample_in, restart);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_windows.size() != 0) @(negedge i_clk);
        // items with no result may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [6:0] size);
        wait_idle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        window_reg = size;
        sizes_used++;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // output side: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_window want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_windows.size() == 0) begin
                report_mismatch($sformatf("unexpected result min %0d max %0d",
                                          $signed(o_m_tdata[31:0]),
                                          $signed(o_m_tdata[63:32])));
            end else begin
                want = expected_windows[0];
                expected_windows.delete(0);
                if (o_m_tdata[31:0] !== want.lo)
                    report_mismatch($sformatf("window_min got %0d expected %0d",
                                              $signed(o_m_tdata[31:0]), want.lo));
                if (o_m_tdata[63:32] !== want.hi)
                    report_mismatch($sformatf("window_max got %0d expected %0d",
                                              $signed(o_m_tdata[63:32]), want.hi));
            end
        end
    end

    // window of one from reset, every item answers with itself
    task automatic test_reset_window();
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'haaaa_aaaa, 1'b0);
    endtask

    // no result until the window fills, equal samples, restart mid-stream
    task automatic test_window_fill();
        write_window(7'd4);
        send_sample(32'd10, 1'b1);
        send_sample(32'd3, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(-32'sd5, 1'b1);
        send_sample(-32'sd5, 1'b0);
        send_sample(-32'sd5, 1'b0);
        send_sample(-32'sd5, 1'b0);
    endtask

    // size zero acts as a window of one
    task automatic test_zero_size();
        write_window(7'd0);
        send_sample(32'd42, 1'b0);
        send_sample(-32'sd42, 1'b0);
    endtask

    // shrink then widen without a restart
    task automatic test_resize_mid_stream();
        write_window(7'd5);
        for (int k = 0; k < 6; k++) send_sample(32'(k * 7 - 20), k == 0);
        write_window(7'd2);
        send_sample(32'd100, 1'b0);
        send_sample(-32'sd100, 1'b0);
        write_window(7'd5);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b0);
    endtask

    // long output hold-off so the unit fills and stalls its input
    task automatic test_receiver_stall();
        write_window(7'd3);
        no_gaps = 1'b1;
        @(posedge i_clk);
        hold_cycles = 150;
        @(negedge i_clk);
        for (int k = 0; k < 40; k++) send_sample(pick_sample(), k == 0);
        no_gaps = 1'b0;
        // sender waits for every result before going on with the stream
        wait_idle();
        for (int k = 0; k < 10; k++) send_sample(pick_sample(), 1'b0);
    endtask

    task automatic test_random_phases();
        int         phase;
        int         len;
        int         w;
        logic [6:0] size;
        logic       restart;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase % 8)
                0: size = 7'($urandom_range(1, 8));
                1: size = 7'd64;
                2: size = 7'($urandom_range(2, 16));
                3: size = 7'd0;
                4: size = 7'd127;
                5: size = 7'($urandom_range(1, 127));
                6: size = 7'd1;
                default: size = 7'($urandom_range(65, 126));
            endcase
            write_window(size);
            w = active_window();
            no_gaps = (phase == 2);
            len = w + $urandom_range(10, 60);
            for (int k = 0; k < len; k++) begin
                if (k == 0) restart = 1'($urandom_range(0, 1));
                else restart = (w <= 16) && ($urandom_range(0, 99) < 3);
                send_sample(pick_sample(), restart);
            end
            random_sent += len;
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_window();
        test_window_fill();
        test_zero_size();
        test_resize_mid_stream();
        test_receiver_stall();
        test_random_phases();
        wait_idle();
        repeat (20) @(negedge i_clk);
        if (expected_windows.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_windows.size()));
        $display("run covered %0d samples and %0d window results over %0d window settings",
                 samples_sent, results_seen, sizes_used);
        if (mismatches == 0) begin
            $display("tb_sliding_window_min_max_unit passed");
        end else begin
            $display("tb_sliding_window_min_max_unit failed");
        end
        $finish;
    end

    initial begin
        #(8 * 400_000);
        $display("timeout waiting on the unit");
        $display("tb_sliding_window_min_max_unit failed");
        $finish;
    end

endmodule

// ===== sliding_window_min_max_unit.f =====
+incdir+rtl/core
rtl/core/swmm_pkg.sv
rtl/core/swmm_cell.sv
rtl/core/sliding_window_min_max_unit.sv
tb/tb_sliding_window_min_max_unit.sv
